// ===== src/btrr_pkg.sv =====
// Shared constants and types for the button timing record/replay unit.
package btrr_pkg;

    // Default number of stored gap entries
    localparam int SLOTS_DEFAULT = 8;

    // Gap counter and stored gap width
    localparam int GAP_W = 16;

    // Timeout limit after reset
    localparam logic [GAP_W-1:0] MAX_GAP_RESET = 16'h0FFF;

    // One stored entry: gap length and toggle mark
    typedef struct packed {
        logic             toggle;
        logic [GAP_W-1:0] gap;
    } t_entry;

endpackage

// ===== src/btrr_store.sv =====
// Gap/toggle entry store: one write port, one registered read port with write forwarding.
module btrr_store #(
    parameter int SLOTS = btrr_pkg::SLOTS_DEFAULT,
    parameter int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  btrr_pkg::t_entry i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output btrr_pkg::t_entry o_rdata
);

    btrr_pkg::t_entry r_mem [SLOTS];
    btrr_pkg::t_entry r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; a same-cycle write to the read address is forwarded
    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/button_timing_record_replay_unit.sv =====
// A result is registered in the output stage when its tick request is accepted.
// One tick per cycle while the skid entry is free; the store is read one entry ahead
// of the playback pointer, so its registered read port keeps pace with back-to-back ticks.
// A two-entry output stage lets a tick be taken while a result waits downstream.
// Reset (synchronous, active low): record mode, pointer, gap counter, last level and
// LED cleared, limit set to 0x0FFF; store contents stay undefined until recorded.
module button_timing_record_replay_unit #(
    parameter int SLOTS = btrr_pkg::SLOTS_DEFAULT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration write
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [btrr_pkg::GAP_W-1:0] i_cfg_data,
    // tick input
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_button_level,
    // result output
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_red_led,
    output logic                       o_recording
);

    localparam int PW = $clog2(SLOTS + 1);
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int GW = btrr_pkg::GAP_W;

    // Control and counter state
    logic [GW-1:0] r_max_gap;
    logic          r_play,  n_play;
    logic [PW-1:0] r_ptr,   n_ptr;
    logic [GW-1:0] r_gap,   n_gap;
    logic          r_prev,  n_prev;
    logic          r_red,   n_red;
    logic          r_cur_tog, n_cur_tog;
    logic          r_rd_beyond, n_rd_beyond;

    // Output stage
    logic r_out_valid, r_skid_valid;
    logic r_out_red, r_out_rec, r_skid_red, r_skid_rec;

    // Store interface
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    btrr_pkg::t_entry mem_wdata;
    logic [AW-1:0]    mem_raddr;
    btrr_pkg::t_entry mem_rdata;

    logic          push, pop;
    logic          chg, full, at_limit;
    logic [PW:0]   next_idx;
    btrr_pkg::t_entry ahead;

    btrr_store #(
        .SLOTS (SLOTS),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_skid_valid;
    assign push        = i_in_valid && o_in_ready;
    assign pop         = r_out_valid && i_out_ready;

    assign chg      = i_button_level != r_prev;
    assign full     = r_ptr == PW'(SLOTS);
    assign at_limit = r_gap == r_max_gap;
    // entry after the current one; reads past the last slot see zero
    assign ahead    = r_rd_beyond ? '0 : mem_rdata;

    // Tick update
    always_comb begin
        n_play    = r_play;
        n_ptr     = r_ptr;
        n_gap     = r_gap;
        n_prev    = r_prev;
        n_red     = r_red;
        n_cur_tog = r_cur_tog;
        mem_we    = 1'b0;
        mem_waddr = r_ptr[AW-1:0];
        mem_wdata = '{toggle: chg, gap: r_gap};
        if (push) begin
            n_prev = i_button_level;
            if (!r_play) begin
                if ((chg && !at_limit) || (!chg && at_limit)) begin
                    if (!full) begin
                        // record an entry, toggle mark on a level change
                        mem_we = 1'b1;
                        n_red  = r_red ^ chg;
                        n_gap  = '0;
                        n_ptr  = r_ptr + PW'(1);
                    end else begin
                        // store full: start playback from slot 0
                        n_play    = 1'b1;
                        n_ptr     = '0;
                        n_gap     = ahead.gap;
                        n_cur_tog = ahead.toggle;
                    end
                end else if (!chg) begin
                    n_gap = r_gap + GW'(1);
                end
            end else begin
                if (r_gap != '0) begin
                    n_gap = r_gap - GW'(1);
                end else if (!full) begin
                    n_red     = r_red ^ r_cur_tog;
                    n_ptr     = r_ptr + PW'(1);
                    n_gap     = ahead.gap;
                    n_cur_tog = ahead.toggle;
                end else begin
                    n_play = 1'b0;
                    n_ptr  = '0;
                end
            end
        end
    end

    // Read-ahead address: slot 0 while recording, next slot while playing
    always_comb begin
        next_idx    = {1'b0, n_ptr} + (PW+1)'(1);
        n_rd_beyond = 1'b0;
        mem_raddr   = '0;
        if (n_play) begin
            if (next_idx >= (PW+1)'(SLOTS)) begin
                n_rd_beyond = 1'b1;
            end else begin
                mem_raddr = next_idx[AW-1:0];
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_gap   <= btrr_pkg::MAX_GAP_RESET;
            r_play      <= 1'b0;
            r_ptr       <= '0;
            r_gap       <= '0;
            r_prev      <= 1'b0;
            r_red       <= 1'b0;
            r_rd_beyond <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_gap <= i_cfg_data;
            end
            r_play      <= n_play;
            r_ptr       <= n_ptr;
            r_gap       <= n_gap;
            r_prev      <= n_prev;
            r_red       <= n_red;
            r_rd_beyond <= n_rd_beyond;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_tog <= n_cur_tog;
    end

    // Output register plus skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || pop) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= push;
            end
        end else if (push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || pop) begin
            if (r_skid_valid) begin
                r_out_red <= r_skid_red;
                r_out_rec <= r_skid_rec;
            end else begin
                r_out_red <= n_red;
                r_out_rec <= !n_play;
            end
        end else if (push) begin
            r_skid_red <= n_red;
            r_skid_rec <= !n_play;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_red_led   = r_out_red;
    assign o_recording = r_out_rec;

    // Checks
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= PW'(SLOTS))
        else $error("slot pointer beyond store depth");

    a_write_in_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (!r_play && !full))
        else $error("store written during playback or when full");

    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty output register");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !i_out_ready))
        else $error("skid filled while output was free");

    a_no_state_change_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !push |=> ($stable(r_ptr) && $stable(r_play)))
        else $error("state changed without a tick");

endmodule
